### rtl/scds_pkg.sv
// ----------------------------------------------------------------------------
// scds_pkg
// Shared widths and reset values for the serial clock divider search.
// ----------------------------------------------------------------------------
package scds_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned PRESCALE_W  = 3;
  localparam int unsigned DIV_SEL_W   = 4;

  localparam int unsigned MAX_PRESCALE_DEF = 7;
  localparam int unsigned MAX_DIV_EXP_DEF  = 8;

  localparam logic [DATA_W-1:0] FREQ_RESET = 32'd24000000;
  localparam logic [DATA_W-1:0] DIST_INIT  = 32'hFFFF_FFFF;

endpackage

### rtl/scds_divider.sv
// ----------------------------------------------------------------------------
// scds_divider
// Restoring divider, one quotient bit per cycle, for a narrow divisor.
// ----------------------------------------------------------------------------
module scds_divider #(
  parameter int unsigned DEN_W = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [scds_pkg::DATA_W-1:0] num_i,
  input  logic [DEN_W-1:0]           den_i,
  output logic                       done_o,
  output logic [scds_pkg::DATA_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(scds_pkg::DATA_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [scds_pkg::DATA_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0]            rem_q, rem_d;
  logic [DEN_W-1:0]            den_q, den_d;
  logic [DEN_W:0]              trial;
  logic                        fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[scds_pkg::DATA_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quo_d = {quo_q[scds_pkg::DATA_W-2:0], fits};
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(scds_pkg::DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/spi_clock_divider_search.sv
// ----------------------------------------------------------------------------
// spi_clock_divider_search
// Picks the prescaler / divider exponent pair whose serial clock rate is
// closest to the requested rate without exceeding it (else the slowest pair).
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the search ends. For each prescaler code the input clock is divided
// by code+1 in a bit-serial divider, then the divider exponents are scanned
// one per cycle by shifting its quotient. An exact match ends the scan
// early. The result appears for one cycle with done_o, in the first cycle
// that busy is low, and cannot be stalled, so capture it then. The clock
// register may be written while the block is idle.
// ----------------------------------------------------------------------------
module spi_clock_divider_search #(
  parameter int unsigned MAX_PRESCALE = scds_pkg::MAX_PRESCALE_DEF,
  parameter int unsigned MAX_DIV_EXP  = scds_pkg::MAX_DIV_EXP_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [scds_pkg::DATA_W-1:0]   target_hz_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [scds_pkg::DATA_W-1:0]   cfg_data_i,
  output logic                          done_o,
  output logic [scds_pkg::PRESCALE_W-1:0] prescale_sel_o,
  output logic [scds_pkg::DIV_SEL_W-1:0]  divider_sel_o
);

  localparam int unsigned P_W = $clog2(MAX_PRESCALE + 1);
  localparam int unsigned D_W = $clog2(MAX_DIV_EXP + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [scds_pkg::DATA_W-1:0] freq_q;
  logic [scds_pkg::DATA_W-1:0] target_q, target_d;
  logic [P_W-1:0]              p_q, p_d;
  logic [D_W-1:0]              d_q, d_d;
  logic [scds_pkg::DATA_W-1:0] best_dist_q, best_dist_d;
  logic [P_W-1:0]              best_p_q, best_p_d;
  logic [D_W-1:0]              best_d_q, best_d_d;
  logic                        done_q, done_d;
  logic [scds_pkg::PRESCALE_W-1:0] psel_q, psel_d;
  logic [scds_pkg::DIV_SEL_W-1:0]  dsel_q, dsel_d;

  logic                        div_start;
  logic [P_W:0]                div_den;
  logic                        div_done;
  logic [scds_pkg::DATA_W-1:0] div_quo;

  logic [D_W:0]                shamt;
  logic [scds_pkg::DATA_W-1:0] rate;
  logic [scds_pkg::DATA_W-1:0] cand_dist;
  logic                        take;

  scds_divider #(
    .DEN_W (P_W + 1)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (freq_q),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // rate of the current pair: quotient for this prescaler shifted by d+1
  assign shamt     = {1'b0, d_q} + 1'b1;
  assign rate      = div_quo >> shamt;
  assign cand_dist = target_q - rate;
  assign take      = (target_q >= rate) && (cand_dist < best_dist_q);

  assign div_den = {1'b0, p_d} + 1'b1;

  always_comb begin
    state_d     = state_q;
    target_d    = target_q;
    p_d         = p_q;
    d_d         = d_q;
    best_dist_d = best_dist_q;
    best_p_d    = best_p_q;
    best_d_d    = best_d_q;
    done_d      = 1'b0;
    psel_d      = psel_q;
    dsel_d      = dsel_q;
    div_start   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          target_d    = target_hz_i;
          p_d         = '0;
          d_d         = '0;
          best_dist_d = scds_pkg::DIST_INIT;
          best_p_d    = P_W'(MAX_PRESCALE);
          best_d_d    = D_W'(MAX_DIV_EXP);
          div_start   = 1'b1;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          d_d     = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (take) begin
          best_dist_d = cand_dist;
          best_p_d    = p_q;
          best_d_d    = d_q;
        end
        // exact match or last pair ends the search
        if ((take && cand_dist == '0) ||
            (d_q == D_W'(MAX_DIV_EXP) && p_q == P_W'(MAX_PRESCALE))) begin
          done_d  = 1'b1;
          psel_d  = scds_pkg::PRESCALE_W'(best_p_d);
          dsel_d  = scds_pkg::DIV_SEL_W'(best_d_d);
          state_d = ST_IDLE;
        end else if (d_q == D_W'(MAX_DIV_EXP)) begin
          p_d       = p_q + 1'b1;
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          d_d = d_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      freq_q  <= scds_pkg::FREQ_RESET;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        freq_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    target_q    <= target_d;
    p_q         <= p_d;
    d_q         <= d_d;
    best_dist_q <= best_dist_d;
    best_p_q    <= best_p_d;
    best_d_q    <= best_d_d;
    psel_q      <= psel_d;
    dsel_q      <= dsel_d;
  end

  assign busy           = state_q != ST_IDLE;
  assign cfg_ready_o    = 1'b1;
  assign done_o         = done_q;
  assign prescale_sel_o = psel_q;
  assign divider_sel_o  = dsel_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while search still running");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not start the search");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside its wait state");

  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (divider_sel_o <= scds_pkg::DIV_SEL_W'(MAX_DIV_EXP)))
    else $error("divider exponent out of range");

endmodule

### bench/spi_clock_divider_search_tb.sv
// ----------------------------------------------------------------------------
// spi_clock_divider_search_tb
// Self-checking bench for the serial clock divider search. Requested rates
// are sent through the start/busy handshake under several input clock
// settings, from zero to all ones. Each item's prescaler and divider codes
// are predicted here by scanning every pair, and each done_o strobe is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module spi_clock_divider_search_tb;
  import scds_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 8000;
  localparam int unsigned SETTLE_CYCLES  = 400;

  typedef struct packed {
    logic [DATA_W-1:0]     target;
    logic [PRESCALE_W-1:0] prescale;
    logic [DIV_SEL_W-1:0]  divider;
  } divider_pair_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic [DATA_W-1:0]     target_hz_i = '0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [DATA_W-1:0]     cfg_data_i  = '0;
  logic                  done_o;
  logic [PRESCALE_W-1:0] prescale_sel_o;
  logic [DIV_SEL_W-1:0]  divider_sel_o;

  divider_pair_t     pending_pairs[$];
  logic [DATA_W-1:0] clock_hz_shadow = FREQ_RESET;
  int unsigned       mismatch_count  = 0;
  int unsigned       stall_cycles    = 0;
  bit                steady          = 1'b0;

  spi_clock_divider_search uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .target_hz_i    (target_hz_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .prescale_sel_o (prescale_sel_o),
    .divider_sel_o  (divider_sel_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // closest rate at or below the target, first pair wins ties, exact match stops
  function automatic divider_pair_t find_divider_pair(logic [DATA_W-1:0] clk_hz,
                                                      logic [DATA_W-1:0] target);
    divider_pair_t     pick;
    logic [63:0]       rate;
    logic [DATA_W-1:0] cand_dist;
    logic [DATA_W-1:0] best;
    pick.target   = target;
    pick.prescale = PRESCALE_W'(MAX_PRESCALE_DEF);
    pick.divider  = DIV_SEL_W'(MAX_DIV_EXP_DEF);
    best = DIST_INIT;
    for (int unsigned p = 0; p <= MAX_PRESCALE_DEF; p++) begin
      for (int unsigned d = 0; d <= MAX_DIV_EXP_DEF; d++) begin
        if (best != '0) begin
          rate = {32'd0, clk_hz} / (64'(p + 1) << (d + 1));
          if ({32'd0, target} >= rate) begin
            cand_dist = target - rate[DATA_W-1:0];
            if (best > cand_dist) begin
              best          = cand_dist;
              pick.prescale = PRESCALE_W'(p);
              pick.divider  = DIV_SEL_W'(d);
            end
          end
        end
      end
    end
    return pick;
  endfunction

  // mostly targets right around a candidate rate, where the choice is delicate
  function automatic logic [DATA_W-1:0] pick_target(logic [DATA_W-1:0] clk_hz);
    int unsigned p;
    int unsigned d;
    logic [63:0] rate;
    p = $urandom_range(0, MAX_PRESCALE_DEF);
    d = $urandom_range(0, MAX_DIV_EXP_DEF);
    rate = {32'd0, clk_hz} / (64'(p + 1) << (d + 1));
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return $urandom_range(0, 16);
      2:       return DIST_INIT - $urandom_range(0, 2);
      3:       return rate[DATA_W-1:0] + $urandom_range(0, rate[DATA_W-1:0] / 4);
      4, 5, 6: return rate[DATA_W-1:0] + $urandom_range(0, 3);
      default: return rate[DATA_W-1:0] - $urandom_range(0, 3);
    endcase
  endfunction

  task automatic send_target(input logic [DATA_W-1:0] target);
    int unsigned gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(0, 99) < 18) gap++;
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    target_hz_i <= target;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_pairs.push_back(find_divider_pair(clock_hz_shadow, target));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_input_clock(input logic [DATA_W-1:0] clk_hz);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= clk_hz;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    clock_hz_shadow = clk_hz;
    cfg_valid_i <= 1'b0;
  endtask

  // reset clock: exact hits, a tie between two pairs, below the slowest rate
  task automatic test_reset_clock();
    send_target(32'd0);
    send_target(32'd1);
    send_target(32'd12000000);
    send_target(32'd11999999);
    send_target(32'd6000000);
    send_target(32'd5859);
    send_target(32'd5858);
    send_target(32'hFFFF_FFFF);
  endtask

  task automatic test_zero_clock();
    write_input_clock(32'd0);
    send_target(32'd0);
    send_target(32'hFFFF_FFFF);
    send_target(32'hFFFF_FFFE);
    send_target(32'h5555_AAAA);
  endtask

  // a single rate of one, two pairs at rate one, and the largest clock
  task automatic test_extreme_clocks();
    write_input_clock(32'd3);
    send_target(32'hFFFF_FFFF);
    send_target(32'd0);
    write_input_clock(32'd4);
    send_target(32'hFFFF_FFFF);
    send_target(32'd0);
    write_input_clock(32'hFFFF_FFFF);
    send_target(32'hFFFF_FFFF);
    send_target(32'h7FFF_FFFF);
    send_target(32'h7FFF_FFFE);
    send_target(32'h0000_0001);
    send_target(32'hAAAA_5555);
  endtask

  task automatic test_random_clocks();
    logic [DATA_W-1:0] clk_hz;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       clk_hz = $urandom();
        1:       clk_hz = $urandom_range(1000000, 100000000);
        3:       clk_hz = $urandom_range(0, 5000);
        4:       clk_hz = 32'd48000000;
        default: clk_hz = $urandom();
      endcase
      write_input_clock(clk_hz);
      steady = (phase == 2);
      for (int i = 0; i < 46; i++) begin
        // sender holds off once mid-phase until all results are back
        if (phase == 1 && i == 23) wait_drained();
        send_target(pick_target(clock_hz_shadow));
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk_i) begin
    divider_pair_t want;
    if (rst_ni && done_o) begin
      if (pending_pairs.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no item pending: prescale %0d divider %0d",
                 $time, prescale_sel_o, divider_sel_o);
      end else begin
        want = pending_pairs.pop_front();
        if (prescale_sel_o !== want.prescale) begin
          mismatch_count++;
          $display("%0t: prescale_sel mismatch, target %0d: expected %0d actual %0d",
                   $time, want.target, want.prescale, prescale_sel_o);
        end
        if (divider_sel_o !== want.divider) begin
          mismatch_count++;
          $display("%0t: divider_sel mismatch, target %0d: expected %0d actual %0d",
                   $time, want.target, want.divider, divider_sel_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o))) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles > WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no progress for %0d cycles", $time, stall_cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_clock();
    test_zero_clock();
    test_extreme_clocks();
    test_random_clocks();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
